@@ hw/rtl/mm64_pkg.sv @@
package mm64_pkg;

    localparam logic [63:0] MurM  = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MurMLo = MurM[31:0];
    localparam logic [31:0] MurMHi = MurM[63:32];
    localparam int unsigned MurR  = 47;
    localparam int unsigned QDepth = 2;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PART,
        KIND_FULL
    } kind_t;

    typedef struct packed {
        logic [63:0] word;
        kind_t       kind;
        logic        last;
        logic        start;
        logic [31:0] total;
    } entry_t;

    typedef struct packed {
        logic        go;
        logic [63:0] operand;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } mul_resp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_MIXK1,
        ST_MIXK2,
        ST_FOLD,
        ST_FINW,
        ST_FIN
    } state_t;

    function automatic logic [63:0] xsr(input logic [63:0] v);
        xsr = v ^ (v >> MurR);
    endfunction

endpackage

@@ hw/rtl/murmur64a_string_hash.sv @@
// Each word passes through the input queue; then a full word takes three 64-bit multiplies
// by M, a partial word one, an empty word none; the first word of a string adds one (seed).
// The last word adds one for finalization; the hash shows in the output register after that.
// Words are hashed one at a time on the single shared 32x32 multiplier
// (three partial products per 64-bit multiply by M). A two-entry queue decouples input.
// Reset (rst_n, async, low) empties the queue and output and arms a new string.
module murmur64a_string_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    output logic        word_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        last_word,
    input  logic [31:0] total_length,
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [63:0] hash_value
);
    import mm64_pkg::*;

    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_not_empty;
    entry_t    push_data;
    entry_t    q_head;
    mul_req_t  mul_req;
    mul_resp_t mul_resp;

    assign word_stall = q_full;

    mm64_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .data_word    (data_word),
        .byte_count   (byte_count),
        .last_word    (last_word),
        .total_length (total_length),
        .q_full       (q_full),
        .push         (push),
        .entry        (push_data)
    );

    mm64_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    mm64_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .resp  (mul_resp)
    );

    mm64_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .mul_req     (mul_req),
        .mul_resp    (mul_resp),
        .hash_valid  (hash_valid),
        .hash_stall  (hash_stall),
        .hash_value  (hash_value)
    );

endmodule

@@ hw/rtl/mm64_front.sv @@
module mm64_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 word_valid,
    input  logic [63:0]          data_word,
    input  logic [3:0]           byte_count,
    input  logic                 last_word,
    input  logic [31:0]          total_length,
    input  logic                 q_full,
    output logic                 push,
    output mm64_pkg::entry_t     entry
);
    import mm64_pkg::*;

    logic        start_reg;
    logic        start_next;
    logic [63:0] mask;

    assign push = word_valid && !q_full;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            mask[8*i +: 8] = ({28'd0, byte_count} > i) ? 8'hff : 8'h00;
        end
    end

    always_comb
    begin
        entry.word  = data_word & mask;
        entry.last  = last_word;
        entry.start = start_reg;
        entry.total = total_length;
        if (byte_count >= 4'd8)
            entry.kind = KIND_FULL;
        else if (byte_count == 4'd0)
            entry.kind = KIND_NONE;
        else
            entry.kind = KIND_PART;
    end

    always_comb
    begin
        start_next = start_reg;
        if (push)
            start_next = last_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_reg <= 1'b1;
        else
            start_reg <= start_next;
    end

endmodule

@@ hw/rtl/mm64_queue.sv @@
module mm64_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mm64_pkg::entry_t     push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output mm64_pkg::entry_t     head
);
    import mm64_pkg::*;

    entry_t             mem_reg [QDepth];
    logic [QPtrW-1:0]   wr_reg, wr_next;
    logic [QPtrW-1:0]   rd_reg, rd_next;
    logic [QCntW-1:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == QCntW'(QDepth));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == QPtrW'(QDepth - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/mm64_mul.sv @@
module mm64_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mm64_pkg::mul_req_t   req,
    output mm64_pkg::mul_resp_t  resp
);
    import mm64_pkg::*;

    // low 64 bits of a*M = aL*ML + ((aH*ML + aL*MH) << 32), one 32x32 product per cycle
    logic [63:0] a_reg, a_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] x, y;
    logic [63:0] prod;
    logic [63:0] addend;

    always_comb
    begin
        x = (step_reg == 2'd1) ? a_reg[63:32] : a_reg[31:0];
        y = (step_reg == 2'd2) ? MurMHi : MurMLo;
        prod = {32'd0, x} * {32'd0, y};
        addend = (step_reg == 2'd0) ? prod : {prod[31:0], 32'd0};
    end

    always_comb
    begin
        a_next    = a_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            a_next    = req.operand;
            step_next = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = ((step_reg == 2'd0) ? 64'd0 : acc_reg) + addend;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign resp.done   = done_reg;
    assign resp.result = acc_reg;

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

@@ hw/rtl/mm64_back.sv @@
module mm64_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_not_empty,
    input  mm64_pkg::entry_t     q_head,
    output logic                 pop,
    output mm64_pkg::mul_req_t   mul_req,
    input  mm64_pkg::mul_resp_t  mul_resp,
    output logic                 hash_valid,
    input  logic                 hash_stall,
    output logic [63:0]          hash_value
);
    import mm64_pkg::*;

    state_t      state_reg, state_next;
    entry_t      ent_reg, ent_next;
    entry_t      ent;
    logic [63:0] h_reg, h_next;
    logic [63:0] out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;
    logic        out_load;
    logic        dispatch;
    logic        finish;
    logic [63:0] h_t;
    logic [63:0] r;

    assign out_free   = !out_valid_reg || !hash_stall;
    assign ent        = (state_reg == ST_IDLE) ? q_head : ent_reg;
    assign r          = mul_resp.result;
    assign hash_valid = out_valid_reg;
    assign hash_value = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        ent_next        = ent_reg;
        h_t             = h_reg;
        pop             = 1'b0;
        mul_req.go      = 1'b0;
        mul_req.operand = '0;
        dispatch        = 1'b0;
        finish          = 1'b0;
        out_load        = 1'b0;
        out_next        = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    pop      = 1'b1;
                    ent_next = q_head;
                    if (q_head.start)
                    begin
                        mul_req.go      = 1'b1;
                        mul_req.operand = {32'd0, q_head.total};
                        state_next      = ST_SEED;
                    end
                    else
                        dispatch = 1'b1;
                end
            end
            ST_SEED:
            begin
                if (mul_resp.done)
                begin
                    h_t      = r;
                    dispatch = 1'b1;
                end
            end
            ST_MIXK1:
            begin
                if (mul_resp.done)
                begin
                    mul_req.go      = 1'b1;
                    mul_req.operand = xsr(r);
                    state_next      = ST_MIXK2;
                end
            end
            ST_MIXK2:
            begin
                if (mul_resp.done)
                begin
                    h_t             = h_reg ^ r;
                    mul_req.go      = 1'b1;
                    mul_req.operand = h_t;
                    state_next      = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (mul_resp.done)
                begin
                    h_t    = r;
                    finish = 1'b1;
                end
            end
            ST_FINW:
            begin
                finish = 1'b1;
            end
            ST_FIN:
            begin
                if (mul_resp.done)
                begin
                    out_load   = 1'b1;
                    out_next   = xsr(r);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (dispatch)
        begin
            case (ent.kind)
                KIND_FULL:
                begin
                    mul_req.go      = 1'b1;
                    mul_req.operand = ent.word;
                    state_next      = ST_MIXK1;
                end
                KIND_PART:
                begin
                    h_t             = h_t ^ ent.word;
                    mul_req.go      = 1'b1;
                    mul_req.operand = h_t;
                    state_next      = ST_FOLD;
                end
                default:
                begin
                    finish = 1'b1;
                end
            endcase
        end

        if (finish)
        begin
            if (ent.last)
            begin
                if (out_free)
                begin
                    mul_req.go      = 1'b1;
                    mul_req.operand = xsr(h_t);
                    state_next      = ST_FIN;
                end
                else
                    state_next = ST_FINW;
            end
            else
                state_next = ST_IDLE;
        end

        h_next = h_t;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!hash_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        h_reg   <= h_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ bench/murmur64a_hash_checker.sv @@
`timescale 1ns / 100ps

module murmur64a_hash_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    input  logic        word_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        last_word,
    input  logic [31:0] total_length,
    input  logic        hash_valid,
    input  logic        hash_stall,
    input  logic [63:0] hash_value,
    output int          fails,
    output int          pending
);

    localparam logic [63:0] MixMul   = 64'hc6a4a7935bd1e995;
    localparam int unsigned MixShift = 47;

    logic [63:0] string_hash = '0;
    logic        string_fresh = 1'b1;
    logic [63:0] hash_expected[$];

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] h;
        logic [63:0] k;
        logic [63:0] want;
        int unsigned nbytes;
        if (!rst_n)
        begin
            string_hash = '0;
            string_fresh = 1'b1;
            hash_expected.delete();
            pending <= 0;
        end
        else
        begin
            if (word_valid && !word_stall)
            begin
                nbytes = (byte_count > 4'd8) ? 8 : int'(byte_count);
                h = string_fresh ? 64'(total_length) * MixMul : string_hash;
                if (nbytes == 8)
                begin
                    k = data_word * MixMul;
                    k = k ^ (k >> MixShift);
                    k = k * MixMul;
                    h = (h ^ k) * MixMul;
                end
                else if (nbytes != 0)
                begin
                    h = (h ^ (data_word & ((64'h1 << (8 * nbytes)) - 64'h1))) * MixMul;
                end
                if (last_word)
                begin
                    h = h ^ (h >> MixShift);
                    h = h * MixMul;
                    h = h ^ (h >> MixShift);
                    hash_expected.push_back(h);
                    string_hash = '0;
                    string_fresh = 1'b1;
                end
                else
                begin
                    string_hash = h;
                    string_fresh = 1'b0;
                end
            end
            if (hash_valid && !hash_stall)
            begin
                if (hash_expected.size() == 0)
                begin
                    if (fails < 10)
                        $display("[%0t] unexpected hash transaction: hash_value=%h",
                                 $realtime, hash_value);
                    fails = fails + 1;
                end
                else
                begin
                    want = hash_expected.pop_front();
                    if (hash_value !== want)
                    begin
                        if (fails < 10)
                            $display("[%0t] hash_value mismatch: expected %h actual %h",
                                     $realtime, want, hash_value);
                        fails = fails + 1;
                    end
                end
            end
            pending <= hash_expected.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        word_valid = 1'b0;
    logic        word_stall;
    logic [63:0] data_word = '0;
    logic [3:0]  byte_count = '0;
    logic        last_word = 1'b0;
    logic [31:0] total_length = '0;
    logic        hash_valid;
    logic        hash_stall = 1'b0;
    logic [63:0] hash_value;

    int fails;
    int pending;
    int words_sent = 0;
    bit quiet = 1'b0;
    bit paused = 1'b0;

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    murmur64a_string_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .data_word    (data_word),
        .byte_count   (byte_count),
        .last_word    (last_word),
        .total_length (total_length),
        .hash_valid   (hash_valid),
        .hash_stall   (hash_stall),
        .hash_value   (hash_value)
    );

    murmur64a_hash_checker hash_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .data_word    (data_word),
        .byte_count   (byte_count),
        .last_word    (last_word),
        .total_length (total_length),
        .hash_valid   (hash_valid),
        .hash_stall   (hash_stall),
        .hash_value   (hash_value),
        .fails        (fails),
        .pending      (pending)
    );

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result-side backpressure in bursts
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            hash_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if (!quiet)
            begin
                hash_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic lst,
                             input logic [31:0] total);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            word_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        word_valid   <= 1'b1;
        data_word    <= w;
        byte_count   <= cnt;
        last_word    <= lst;
        total_length <= total;
        @(posedge clk);
        while (word_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_string(input int unsigned len, input logic [31:0] total);
        int unsigned left;
        int unsigned n;
        logic [63:0] w;
        left = len;
        if (len == 0)
            send_word(64'h0, 4'd0, 1'b1, total);
        while (left > 0)
        begin
            n = (left >= 8) ? 8 : left;
            w = {$urandom, $urandom};
            if (n < 8)
                w = w & ((64'h1 << (8 * n)) - 64'h1);
            left -= n;
            send_word(w, 4'(n), left == 0, total);
        end
    endtask

    // malformed strings: any byte count, dirty high bytes, arbitrary lengths
    task automatic send_noise();
        int unsigned k;
        k = $urandom_range(1, 6);
        for (int unsigned i = 0; i < k; i++)
            send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), i == k - 1, $urandom);
    endtask

    task automatic drain();
        word_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(64'h0, 4'd0, 1'b1, 32'd0);
        send_word(64'hff, 4'd1, 1'b1, 32'd1);
        send_word(64'h00ff_ffff_ffff_ffff, 4'd7, 1'b1, 32'd7);
        send_word('1, 4'd8, 1'b1, 32'd8);
        send_word(64'h0, 4'd8, 1'b1, 32'd8);
        send_string(9, 9);
        send_word('1, 4'd15, 1'b1, 32'hffff_ffff);
        send_word({$urandom, $urandom}, 4'd0, 1'b0, 32'd11);
        send_word({$urandom, $urandom}, 4'd8, 1'b0, 32'd11);
        send_word(64'h0000_0000_0012_3456, 4'd3, 1'b1, 32'd11);
        send_word(64'h1234, 4'd2, 1'b0, 32'd5);
        send_word(64'hab, 4'd1, 1'b1, 32'd5);
        send_word('1, 4'd3, 1'b1, 32'd3);
        send_word({$urandom, $urandom}, 4'd8, 1'b0, 32'hffff_ffff);
        send_word({$urandom, $urandom}, 4'd8, 1'b1, 32'd0);
        send_string(16, 16);
        send_word({$urandom, $urandom}, 4'd9, 1'b0, 32'd20);
        send_word({$urandom, $urandom}, 4'd12, 1'b1, 32'd20);
        drain();

        while (words_sent < 500)
        begin
            if (words_sent >= 440)
                quiet = 1'b1;
            pick = $urandom_range(0, 9);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 40);
            if (pick < 7)
                send_string(len, len);
            else if (pick == 7)
                send_string(len, $urandom);
            else
                send_noise();
            if (!paused && words_sent >= 250)
            begin
                paused = 1'b1;
                drain();
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
